@@ hdl/bba_pkg.sv @@
// Shared constants and types for the bitmap block allocator.
package bba_pkg;

    localparam int MAX_BLOCKS_DEF    = 1024;
    localparam int MAP_WORD_BITS_DEF = 32;
    localparam int TOTAL_W           = 11;
    localparam int BLOCK_W           = 10;
    localparam int OP_W              = 2;
    localparam int STATUS_W          = 2;
    localparam int FIRST_ALLOC_BLOCK = 3;
    localparam int S_TDATA_W         = 16;
    localparam int M_TDATA_W         = 16;
    localparam int M_PAD_W           = M_TDATA_W - 1 - BLOCK_W - STATUS_W;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 11'd1024;

    typedef enum logic [OP_W-1:0] {
        OP_QUERY = 2'd0,
        OP_FREE  = 2'd1,
        OP_ALLOC = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_ZERO  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

endpackage

@@ hdl/bitmap_block_allocator_unit.sv @@
// Bitmap first-fit block allocator, top level.
//
// Input channel s_axis carries one operation per transfer: query a block,
// free a block, or allocate the lowest free block from block 3 up to the
// configured block count. Output channel m_axis returns one result per
// operation, in order. The user must write the block count through
// i_cfg_wr_en / i_cfg_wr_data only while the unit is idle; it is not enforced.
//
// One operation is in work at a time. Query and free pass through bitmap read,
// update and output load in turn, and s_axis_tready returns with the result.
// An allocate reads one bitmap word per cycle through the one read port.
//
// After reset every block is in use: a clearing pass writes zero to every
// bitmap word with s_axis_tready low. The block count returns to 1024. A
// stalled m_axis holds its result in the output register; one more
// operation is taken meanwhile and its result waits inside until the output
// register is free.
module bitmap_block_allocator_unit
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS    = MAX_BLOCKS_DEF,
    parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [TOTAL_W-1:0]   i_cfg_wr_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [1:0] op, [11:2] block_number, [15:12] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] block_free, [10:1] allocated_block, [12:11] status, [15:13] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int MAP_WORDS = MAX_BLOCKS / MAP_WORD_BITS;
    localparam int BIT_W     = $clog2(MAP_WORD_BITS);
    localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int LIM_W     = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W     = (LIM_W > TOTAL_W) ? LIM_W : TOTAL_W;
    localparam logic [CMP_W-1:0] MAX_LIM   = CMP_W'(MAX_BLOCKS);
    localparam logic [WA_W-1:0]  LAST_WORD = WA_W'(MAP_WORDS - 1);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_RD,
        S_EXE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [TOTAL_W-1:0]     r_total;
    logic [OP_W-1:0]        r_op;
    logic [BLOCK_W-1:0]     r_blk;
    logic                   r_in_range;
    logic [WA_W-1:0]        r_clr;
    logic [WA_W:0]          r_rd_word;
    logic                   r_chk_v;
    logic [WA_W-1:0]        r_chk_word;
    logic                   r_res_free;
    logic [BLOCK_W-1:0]     r_res_blk;
    t_status                r_res_status;
    logic                   r_out_valid;
    logic [M_TDATA_W-1:0]   r_out_data;

    logic [CMP_W-1:0]         total_ext;
    logic [CMP_W-1:0]         lim;
    logic [CMP_W-1:0]         in_blk_ext;
    logic [CMP_W-1:0]         blk_ext;
    logic [WA_W-1:0]          blk_word;
    logic [BIT_W-1:0]         blk_bit;
    logic [CMP_W-1:0]         rd_base;
    logic [CMP_W-1:0]         chk_base;
    logic                     issue;
    logic                     scan_found;
    logic [BIT_W-1:0]         scan_idx;
    logic [MAP_WORD_BITS-1:0] blk_onehot;
    logic [MAP_WORD_BITS-1:0] hit_onehot;
    logic [BLOCK_W-1:0]       alloc_blk;

    logic                     ram_re;
    logic [WA_W-1:0]          ram_raddr;
    logic [MAP_WORD_BITS-1:0] ram_rdata;
    logic                     ram_we;
    logic [WA_W-1:0]          ram_waddr;
    logic [MAP_WORD_BITS-1:0] ram_wdata;

    assign total_ext  = CMP_W'(r_total);
    assign lim        = (total_ext > MAX_LIM) ? MAX_LIM : total_ext;
    assign in_blk_ext = CMP_W'(s_axis_tdata[OP_W +: BLOCK_W]);
    assign blk_ext    = CMP_W'(r_blk);
    assign blk_word   = blk_ext[BIT_W +: WA_W];
    assign blk_bit    = blk_ext[BIT_W-1:0];
    assign rd_base    = CMP_W'({r_rd_word, {BIT_W{1'b0}}});
    assign chk_base   = CMP_W'({r_chk_word, {BIT_W{1'b0}}});
    assign issue      = (r_state == S_SCAN) && (rd_base < lim);
    assign blk_onehot = MAP_WORD_BITS'(1) << blk_bit;
    assign hit_onehot = MAP_WORD_BITS'(1) << scan_idx;
    assign alloc_blk  = BLOCK_W'({r_chk_word, scan_idx});

    bba_word_scan #(
        .WORD_BITS (MAP_WORD_BITS),
        .CMP_W     (CMP_W),
        .BIT_W     (BIT_W)
    ) u_scan (
        .i_word  (ram_rdata),
        .i_base  (chk_base),
        .i_lim   (lim),
        .o_found (scan_found),
        .o_idx   (scan_idx)
    );

    bba_map_ram #(
        .WORDS (MAP_WORDS),
        .WIDTH (MAP_WORD_BITS),
        .AW    (WA_W)
    ) u_map (
        .i_clk   (i_clk),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata)
    );

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = blk_word;
        ram_we    = 1'b0;
        ram_waddr = blk_word;
        ram_wdata = ram_rdata | blk_onehot;
        case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            S_RD: begin
                ram_re = 1'b1;
            end
            S_EXE: begin
                ram_we = (r_op == OP_FREE) && (r_blk != '0) && r_in_range;
            end
            S_SCAN: begin
                ram_re    = issue;
                ram_raddr = r_rd_word[WA_W-1:0];
                ram_we    = r_chk_v && scan_found;
                ram_waddr = r_chk_word;
                ram_wdata = ram_rdata & ~hit_onehot;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_total     <= TOTAL_RESET;
            r_clr       <= '0;
            r_chk_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_total <= i_cfg_wr_data;
            end
            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LAST_WORD) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op       <= s_axis_tdata[OP_W-1:0];
                        r_blk      <= s_axis_tdata[OP_W +: BLOCK_W];
                        r_in_range <= in_blk_ext < lim;
                        r_rd_word  <= '0;
                        r_chk_v    <= 1'b0;
                        r_state    <= (s_axis_tdata[OP_W-1:0] == OP_ALLOC) ? S_SCAN : S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_EXE;
                end
                S_EXE: begin
                    r_res_free   <= 1'b0;
                    r_res_blk    <= '0;
                    r_res_status <= ST_OK;
                    case (r_op)
                        OP_QUERY: begin
                            r_res_free <= r_in_range && ram_rdata[blk_bit];
                        end
                        OP_FREE: begin
                            if (r_blk == '0) begin
                                r_res_status <= ST_ZERO;
                            end else if (!r_in_range) begin
                                r_res_status <= ST_RANGE;
                            end
                        end
                        default: begin
                        end
                    endcase
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    if (issue) begin
                        r_rd_word <= r_rd_word + 1'b1;
                    end
                    r_chk_v    <= issue;
                    r_chk_word <= r_rd_word[WA_W-1:0];
                    if (r_chk_v && scan_found) begin
                        r_res_free   <= 1'b0;
                        r_res_blk    <= alloc_blk;
                        r_res_status <= ST_OK;
                        r_state      <= S_DONE;
                    end else if (!r_chk_v && !issue) begin
                        r_res_free   <= 1'b0;
                        r_res_blk    <= '0;
                        r_res_status <= ST_FULL;
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {{M_PAD_W{1'b0}}, r_res_status, r_res_blk, r_res_free};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ hdl/bba_map_ram.sv @@
// Free-block bitmap memory, one write and one registered read port.
module bba_map_ram #(
    parameter int WORDS = 32,
    parameter int WIDTH = 32,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata
);

    logic [WIDTH-1:0] mem [WORDS];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/bba_word_scan.sv @@
// Lowest free block search within one bitmap word, limited to the allocatable range.
module bba_word_scan
    import bba_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int CMP_W     = 11,
    parameter int BIT_W     = 5
) (
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [CMP_W-1:0]     i_base,
    input  logic [CMP_W-1:0]     i_lim,
    output logic                 o_found,
    output logic [BIT_W-1:0]     o_idx
);

    logic [CMP_W-1:0]     rem;
    logic [WORD_BITS-1:0] masked;

    assign rem = i_lim - i_base;

    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            masked[i] = i_word[i] && (CMP_W'(i) < rem)
                        && !((i_base == '0) && (i < FIRST_ALLOC_BLOCK));
        end
    end

    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (masked[i]) begin
                o_found = 1'b1;
                o_idx   = BIT_W'(i);
            end
        end
    end

endmodule

@@ hdl/bba_checker.sv @@
// Port-level checks for the bitmap block allocator and their binding.
module bba_checker
    import bba_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second operation taken while one is in work");

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !s_axis_tready)
        else $error("operation taken during bitmap clearing");

    a_full_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[12:11] == ST_FULL)) |-> (m_axis_tdata[10:0] == '0))
        else $error("full result carries a block or free flag");

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
